### rtl/lcrid_pkg.sv
// Package: phase codes, escape codes and widths for the line-copy run decompressor.
package lcrid_pkg;
    localparam int MAX_WIDTH = 2048;
    localparam int HIST_DEPTH = 2 * MAX_WIDTH;
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int POS_W = 27;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_COUNT     = 4'd1;
    localparam logic [3:0] PH_A_LO      = 4'd2;
    localparam logic [3:0] PH_A_HI      = 4'd3;
    localparam logic [3:0] PH_B_LO      = 4'd4;
    localparam logic [3:0] PH_B_HI      = 4'd5;
    localparam logic [3:0] PH_LIT_HI    = 4'd6;
    localparam logic [3:0] PH_LIT_LO    = 4'd7;
    localparam logic [3:0] PH_RUN       = 4'd8;
    localparam logic [3:0] PH_PACK_HIGH = 4'd9;
    localparam logic [3:0] PH_PACK_LOW  = 4'd10;

    localparam logic [7:0] OP_UP1   = 8'hFF;
    localparam logic [7:0] OP_UP2   = 8'hFE;
    localparam logic [7:0] OP_FILL  = 8'hFD;
    localparam logic [7:0] OP_FILL2 = 8'hFC;
    localparam logic [7:0] OP_UL    = 8'hFB;
    localparam logic [7:0] OP_UR    = 8'hFA;
    localparam logic [7:0] OP_PACK  = 8'hF9;
    localparam logic [7:0] OP_LIT   = 8'hF8;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_WIDE   = 2'd2;
endpackage

### rtl/line_copy_run_image_decompressor_top.sv
// Top level: line-copy run image decompressor with a two-row pixel history memory.
//
// s_axis carries one item per cycle while s_axis_tready is high: tuser = action
// (1 drain tick, 0 byte offer), tdata = code_byte. Each accepted item yields exactly
// one result on m_axis: tuser = pixel_valid, tdata = pixel_value in bits 15:0 and
// byte_taken in bit 16, tlast = frame_end.
// During a run every item emits one run pixel and refuses the offered byte
// (byte_taken 0), so the source resends it.
// Each result is registered in the output queue before it is offered on m_axis.
// One item is accepted per cycle while the output queue has room: stage 1 issues
// the history read for the neighbor the item needs, stage 2 decodes with the read
// data and writes the pixel back. Neighbor addresses are computed from a predicted
// position, and a write in stage 2 to the entry being read is forwarded into stage 2.
// While the receiver stalls, up to two results wait in a two-entry output queue;
// s_axis_tready drops as soon as the item in stage 2 would take the last entry.
// Configuration is to be written over cfg_we/cfg_addr/cfg_wdata only while idle;
// the block does not enforce it. Reset (aresetn low, synchronous) clears the parse
// state and position; the history memory is not cleared: reads above the first row
// return zero by position checks. Widths of 0 act as 1, above 2048 as 2048;
// height 0 as 1.
module line_copy_run_image_decompressor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // code_byte
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // pixel_value[15:0], byte_taken
    output logic        m_axis_tuser,   // pixel_valid
    output logic        m_axis_tlast    // frame_end
);
    import lcrid_pkg::*;

    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic        wide_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  op_reg, op_next;
    logic [9:0]  run_reg, run_next;
    logic [15:0] ca_reg, ca_next, cb_reg, cb_next, hh_reg, hh_next;
    logic        sec_reg, sec_next;
    logic [7:0]  lb_reg, lb_next;

    logic [15:0] hist [HIST_DEPTH];
    logic [15:0] rd_data_reg;

    // output skid buffer
    logic [18:0] q0_reg, q1_reg;
    logic        q0v_reg, q1v_reg;

    logic        accept;
    logic        s2_v_reg;
    logic        s2_act_reg;
    logic [7:0]  s2_byte_reg;
    logic        s2_dok_reg;
    logic [HIST_AW-1:0] s2_raddr_reg;

    // effective width
    logic [12:0] weff;
    always_comb begin
        if (width_reg == 12'd0) weff = 13'd1;
        else if ({1'b0, width_reg} > 13'(MAX_WIDTH)) weff = 13'(MAX_WIDTH);
        else weff = {1'b0, width_reg};
    end
    logic [15:0] heff;
    assign heff = (height_reg == 16'd0) ? 16'd1 : height_reg;
    logic [POS_W:0] total_reg;
    always_ff @(posedge aclk) total_reg <= (POS_W+1)'(weff * heff);

    assign s_axis_tready = !(q0v_reg && q1v_reg) && !(s2_v_reg && q0v_reg && !m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;

    // ---------------- stage 2 decode (uses committed state) ----------------
    logic [15:0] nb;
    logic        emit;
    logic [15:0] ev;
    logic        taken;
    logic        fend;
    logic        wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [15:0] wr_val;
    logic [15:0] nb_raw;
    logic [POS_W:0] pos1;

    // forwarding: stage 2 reads data written by the previous stage-2 item
    logic        fw_v_reg;
    logic [HIST_AW-1:0] fw_a_reg;
    logic [15:0] fw_d_reg;
    assign nb_raw = (fw_v_reg && fw_a_reg == s2_raddr_reg) ? fw_d_reg : rd_data_reg;
    assign nb = s2_dok_reg ? nb_raw : 16'd0;
    assign pos1 = {1'b0, pos_reg} + 1'b1;

    always_comb begin
        logic [15:0] v;
        logic [9:0]  add;
        logic [9:0]  cnt;
        logic        start;
        logic        dec;
        v = 16'd0; add = 10'd0; cnt = 10'd0; start = 1'b0; dec = 1'b0;
        emit = 1'b0; taken = 1'b0;
        pos_next = pos_reg; phase_next = phase_reg; op_next = op_reg;
        run_next = run_reg; ca_next = ca_reg; cb_next = cb_reg; hh_next = hh_reg;
        sec_next = sec_reg; lb_next = lb_reg;
        if (phase_reg == PH_RUN) begin
            emit = 1'b1; dec = 1'b1;
            if (op_reg == OP_UP1 || op_reg == OP_UP2) v = nb;
            else if (op_reg == OP_FILL2) begin
                v = sec_reg ? cb_reg : ca_reg;
                sec_next = !sec_reg;
            end else v = ca_reg;
        end else if (!s2_act_reg) begin
            taken = 1'b1;
            case (phase_reg)
                PH_IDLE: begin
                    op_next = s2_byte_reg;
                    if (s2_byte_reg == OP_UP1 || s2_byte_reg == OP_UP2 ||
                        s2_byte_reg == OP_FILL || s2_byte_reg == OP_FILL2 ||
                        (wide_reg && s2_byte_reg == OP_PACK)) phase_next = PH_COUNT;
                    else if (s2_byte_reg == OP_LIT) phase_next = PH_LIT_LO;
                    else if (wide_reg && (s2_byte_reg == OP_UL || s2_byte_reg == OP_UR)) begin
                        emit = 1'b1; v = nb;
                    end else if (wide_reg) begin
                        lb_next = s2_byte_reg; phase_next = PH_LIT_HI;
                    end else begin
                        emit = 1'b1; v = {8'd0, s2_byte_reg};
                    end
                end
                PH_COUNT: begin
                    if (op_reg == OP_FILL) add = wide_reg ? 10'd3 : 10'd4;
                    else if (op_reg == OP_PACK) add = 10'd1;
                    else add = wide_reg ? 10'd2 : 10'd3;
                    run_next = {2'b0, s2_byte_reg} + add;
                    if (op_reg == OP_UP1 || op_reg == OP_UP2) begin
                        start = 1'b1; cnt = {2'b0, s2_byte_reg} + add;
                    end else if (op_reg == OP_PACK) phase_next = PH_PACK_HIGH;
                    else phase_next = PH_A_LO;
                end
                PH_A_LO: begin
                    ca_next = {8'd0, s2_byte_reg};
                    if (wide_reg) phase_next = PH_A_HI;
                    else if (op_reg == OP_FILL2) phase_next = PH_B_LO;
                    else begin
                        start = 1'b1; cnt = run_reg;
                    end
                end
                PH_A_HI: begin
                    ca_next = {s2_byte_reg, ca_reg[7:0]};
                    if (op_reg == OP_FILL2) phase_next = PH_B_LO;
                    else begin
                        start = 1'b1; cnt = run_reg;
                    end
                end
                PH_B_LO: begin
                    cb_next = {8'd0, s2_byte_reg};
                    if (wide_reg) phase_next = PH_B_HI;
                    else begin
                        start = 1'b1; cnt = {run_reg[8:0], 1'b0};
                    end
                end
                PH_B_HI: begin
                    cb_next = {s2_byte_reg, cb_reg[7:0]};
                    start = 1'b1; cnt = {run_reg[8:0], 1'b0};
                end
                PH_LIT_LO: begin
                    if (wide_reg) begin
                        lb_next = s2_byte_reg; phase_next = PH_LIT_HI;
                    end else begin
                        phase_next = PH_IDLE; emit = 1'b1; v = {8'd0, s2_byte_reg};
                    end
                end
                PH_LIT_HI: begin
                    phase_next = PH_IDLE; emit = 1'b1; v = {s2_byte_reg, lb_reg};
                end
                PH_PACK_HIGH: begin
                    hh_next = {s2_byte_reg[7:5], 2'd0, s2_byte_reg[4:3], 4'd0,
                               s2_byte_reg[2:0], 2'd0};
                    phase_next = PH_PACK_LOW;
                end
                PH_PACK_LOW: begin
                    emit = 1'b1; dec = 1'b1;
                    v = hh_reg | {3'd0, s2_byte_reg[7:6], 2'd0, s2_byte_reg[5:2],
                                  3'd0, s2_byte_reg[1:0]};
                end
                default: phase_next = PH_IDLE;
            endcase
            if (start) begin
                // first run pixel is emitted with this same item; copy runs reach here
                // with op FF/FE after a count byte, whose neighbor was read for that op
                run_next = cnt; sec_next = 1'b0; phase_next = PH_RUN;
                emit = 1'b1; dec = 1'b1;
                if (op_reg == OP_UP1 || op_reg == OP_UP2) v = nb;
                else v = ca_next;
                if (op_reg == OP_FILL2) sec_next = 1'b1;
            end
        end
        if (!wide_reg) v[15:8] = 8'd0;
        ev = v;
        fend = emit && (pos1 >= total_reg);
        if (emit) begin
            if (fend) begin
                pos_next = '0; phase_next = PH_IDLE; run_next = 10'd0; sec_next = 1'b0;
            end else begin
                pos_next = pos1[POS_W-1:0];
                if (dec) begin
                    if (run_next != 10'd0) run_next = run_next - 1'b1;
                    if (run_next == 10'd0) begin
                        phase_next = PH_IDLE; sec_next = 1'b0;
                    end
                end
            end
        end
    end

    assign wr_en = s2_v_reg && emit;
    assign wr_addr = HIST_AW'(pos_reg % HIST_DEPTH);
    assign wr_val = ev;

    // ---------------- stage 1: predicted state and read address ----------------
    // predict phase/op/position as they will be when this item reaches stage 2
    logic [3:0]  pph;
    logic [7:0]  pop;
    logic [POS_W-1:0] ppos;
    logic        nd_act;
    logic [12:0] back_d;
    logic        need;
    assign pph  = s2_v_reg ? phase_next : phase_reg;
    assign pop  = s2_v_reg ? op_next : op_reg;
    assign ppos = s2_v_reg ? pos_next : pos_reg;
    assign nd_act = s_axis_tuser;
    always_comb begin
        logic [7:0] o;
        need = 1'b0; back_d = 13'd0;
        o = (pph == PH_IDLE) ? s_axis_tdata : pop;
        if (pph == PH_RUN || pph == PH_COUNT) begin
            if (o == OP_UP1) begin need = 1'b1; back_d = weff; end
            else if (o == OP_UP2) begin need = 1'b1; back_d = {weff[11:0], 1'b0}; end
        end else if (pph == PH_IDLE && !nd_act && wide_reg) begin
            if (o == OP_UL) begin need = 1'b1; back_d = weff + 1'b1; end
            else if (o == OP_UR) begin need = 1'b1; back_d = weff - 1'b1; end
        end
    end
    logic dok;
    logic [POS_W-1:0] raddr_full;
    assign dok = need && back_d != 13'd0 && {{(POS_W-13){1'b0}}, back_d} <= ppos;
    assign raddr_full = ppos - {{(POS_W-13){1'b0}}, back_d};

    always_ff @(posedge aclk) begin
        if (wr_en) hist[wr_addr] <= wr_val;
        rd_data_reg <= hist[raddr_full[HIST_AW-1:0]];
        fw_v_reg <= wr_en;
        fw_a_reg <= wr_addr;
        fw_d_reg <= wr_val;
    end

    // result packing
    logic [18:0] res;
    assign res = {fend, taken, emit ? ev : 16'd0, emit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 12'd1; height_reg <= 16'd1; wide_reg <= 1'b1;
            pos_reg <= '0; phase_reg <= PH_IDLE; op_reg <= 8'd0; run_reg <= 10'd0;
            ca_reg <= 16'd0; cb_reg <= 16'd0; sec_reg <= 1'b0; hh_reg <= 16'd0;
            lb_reg <= 8'd0; s2_v_reg <= 1'b0; q0v_reg <= 1'b0; q1v_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_WIDTH:  width_reg <= cfg_wdata[11:0];
                    CFG_HEIGHT: height_reg <= cfg_wdata;
                    CFG_WIDE:   wide_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s2_v_reg) begin
                pos_reg <= pos_next; phase_reg <= phase_next; op_reg <= op_next;
                run_reg <= run_next; ca_reg <= ca_next; cb_reg <= cb_next;
                sec_reg <= sec_next; hh_reg <= hh_next; lb_reg <= lb_next;
            end
            s2_v_reg <= accept;
            // two-entry output queue
            if (q0v_reg && m_axis_tready) begin
                if (q1v_reg) begin
                    q0_reg <= q1_reg; q1v_reg <= s2_v_reg;
                    if (s2_v_reg) q1_reg <= res;
                end else if (s2_v_reg) q0_reg <= res;
                else q0v_reg <= 1'b0;
            end else if (s2_v_reg) begin
                if (!q0v_reg) begin q0_reg <= res; q0v_reg <= 1'b1; end
                else begin q1_reg <= res; q1v_reg <= 1'b1; end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_act_reg <= s_axis_tuser; s2_byte_reg <= s_axis_tdata;
            s2_dok_reg <= dok;
            s2_raddr_reg <= raddr_full[HIST_AW-1:0];
        end
    end

    assign m_axis_tvalid = q0v_reg;
    assign m_axis_tuser = q0_reg[0];
    assign m_axis_tdata = {7'd0, q0_reg[17:1]};
    assign m_axis_tlast = q0_reg[18];
endmodule

### tb/sv/line_copy_run_image_decompressor_top_test.sv
// Testbench: directed and random byte streams checked against a built-in decoder predictor.
`timescale 1ns / 1ps

module line_copy_run_image_decompressor_top_test;
    import lcrid_pkg::*;

    typedef struct packed {
        logic        fend;
        logic        taken;
        logic [15:0] value;
        logic        valid;
    } pixel_res_t;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // code_byte
    logic        s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // pixel_value[15:0], byte_taken
    logic        m_axis_tuser;   // pixel_valid
    logic        m_axis_tlast;   // frame_end

    line_copy_run_image_decompressor_top DUT (.*);

    // decoder state mirror
    logic [15:0] hist_mem [HIST_DEPTH];
    longint unsigned pos;
    logic [3:0]  phase;
    logic [7:0]  cur_op;
    int unsigned run_cnt;
    logic [15:0] col_a, col_b, hi_half;
    logic [7:0]  lo_byte;
    bit          alt;
    int unsigned cfg_w, cfg_h;
    bit          cfg_wide;
    pixel_res_t  nxt;

    pixel_res_t  pixel_q[$];
    int          errors = 0;
    int          n_pixels = 0, n_frames = 0, n_refused = 0, n_items = 0;
    longint      cycles = 0;
    bit          no_idle = 0;
    bit          last_taken;

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    function automatic longint unsigned eff_w();
        longint unsigned w;
        w = cfg_w;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic logic [15:0] hist_back(longint unsigned d);
        if (d == 0 || d > pos) return 16'h0;
        return hist_mem[(pos - d) % HIST_DEPTH];
    endfunction

    function automatic bit put_pixel(logic [15:0] v);
        longint unsigned total;
        total = eff_w() * ((cfg_h == 0) ? 1 : cfg_h);
        if (!cfg_wide) v[15:8] = 8'h0;
        hist_mem[pos % HIST_DEPTH] = v;
        nxt.valid = 1'b1;
        nxt.value = v;
        if (pos + 1 >= total) begin
            nxt.fend = 1'b1;
            pos = 0;
            phase = PH_IDLE;
            run_cnt = 0;
            alt = 0;
            return 1;
        end
        pos++;
        return 0;
    endfunction

    function automatic void run_pixel();
        logic [15:0] v;
        if (cur_op == OP_UP1) v = hist_back(eff_w());
        else if (cur_op == OP_UP2) v = hist_back(2 * eff_w());
        else if (cur_op == OP_FILL2) begin
            v = alt ? col_b : col_a;
            alt = !alt;
        end else v = col_a;
        if (put_pixel(v)) return;
        if (run_cnt > 0) run_cnt--;
        if (run_cnt == 0) begin
            phase = PH_IDLE;
            alt = 0;
        end
    endfunction

    function automatic void start_run(int unsigned n);
        run_cnt = n & 10'h3FF;
        alt = 0;
        phase = PH_RUN;
        run_pixel();
    endfunction

    function automatic void after_colours();
        if (cur_op == OP_FILL2) start_run(run_cnt * 2);
        else start_run(run_cnt);
    endfunction

    function automatic void take_byte(logic [7:0] b);
        int unsigned add;
        bit          done;
        case (phase)
            PH_IDLE: begin
                cur_op = b;
                if (b == OP_UP1 || b == OP_UP2 || b == OP_FILL || b == OP_FILL2 ||
                    (cfg_wide && b == OP_PACK)) phase = PH_COUNT;
                else if (b == OP_LIT) phase = PH_LIT_LO;
                else if (cfg_wide && b == OP_UL) done = put_pixel(hist_back(eff_w() + 1));
                else if (cfg_wide && b == OP_UR) done = put_pixel(hist_back(eff_w() - 1));
                else if (cfg_wide) begin
                    lo_byte = b;
                    phase = PH_LIT_HI;
                end else done = put_pixel({8'h0, b});
            end
            PH_COUNT: begin
                if (cur_op == OP_FILL) add = cfg_wide ? 3 : 4;
                else if (cur_op == OP_PACK) add = 1;
                else add = cfg_wide ? 2 : 3;
                run_cnt = b + add;
                if (cur_op == OP_UP1 || cur_op == OP_UP2) start_run(run_cnt);
                else if (cur_op == OP_PACK) phase = PH_PACK_HIGH;
                else phase = PH_A_LO;
            end
            PH_A_LO: begin
                col_a = {8'h0, b};
                if (cfg_wide) phase = PH_A_HI;
                else if (cur_op == OP_FILL2) phase = PH_B_LO;
                else after_colours();
            end
            PH_A_HI: begin
                col_a[15:8] = b;
                if (cur_op == OP_FILL2) phase = PH_B_LO;
                else after_colours();
            end
            PH_B_LO: begin
                col_b = {8'h0, b};
                if (cfg_wide) phase = PH_B_HI;
                else after_colours();
            end
            PH_B_HI: begin
                col_b[15:8] = b;
                after_colours();
            end
            PH_LIT_LO: begin
                if (cfg_wide) begin
                    lo_byte = b;
                    phase = PH_LIT_HI;
                end else begin
                    phase = PH_IDLE;
                    done = put_pixel({8'h0, b});
                end
            end
            PH_LIT_HI: begin
                phase = PH_IDLE;
                done = put_pixel({b, lo_byte});
            end
            PH_PACK_HIGH: begin
                hi_half = {b[7:5], 2'b0, b[4:3], 4'b0, b[2:0], 2'b0};
                phase = PH_PACK_LOW;
            end
            PH_PACK_LOW: begin
                if (!put_pixel(hi_half | {3'b0, b[7:6], 2'b0, b[5:2], 3'b0, b[1:0]})) begin
                    if (run_cnt > 0) run_cnt--;
                    if (run_cnt == 0) phase = PH_IDLE;
                end
            end
            default: phase = PH_IDLE;
        endcase
    endfunction

    function automatic pixel_res_t decode_item(bit act, logic [7:0] b);
        nxt = '0;
        if (phase == PH_RUN) run_pixel();
        else if (!act) begin
            nxt.taken = 1'b1;
            take_byte(b);
        end
        return nxt;
    endfunction

    always @(negedge aclk)
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pixel_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, actual %h", $time, m_axis_tdata);
            end else begin
                pixel_res_t want;
                pixel_res_t got;
                want = pixel_q.pop_front();
                got = {m_axis_tlast, m_axis_tdata[16:0], m_axis_tuser};
                if (got.valid !== want.valid || got.value !== want.value ||
                    got.taken !== want.taken || got.fend !== want.fend ||
                    m_axis_tdata[23:17] !== 7'b0) begin
                    errors++;
                    $display("%0t: mismatch expected v=%b px=%h t=%b e=%b",
                             $time, want.valid, want.value, want.taken, want.fend);
                    $display("    actual v=%b px=%h t=%b e=%b",
                             got.valid, got.value, got.taken, got.fend);
                end
                n_pixels += got.valid;
                n_frames += got.fend;
            end
        end
    end

    task automatic send_item(bit act, logic [7:0] b);
        pixel_res_t r;
        while (!no_idle && $urandom_range(99) < 34) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = act;
        s_axis_tdata = b;
        do @(posedge aclk); while (!s_axis_tready);
        r = decode_item(act, b);
        pixel_q.push_back(r);
        last_taken = r.taken;
        if (!act && !r.taken) n_refused++;
        n_items++;
        @(negedge aclk);
    endtask

    task automatic push_byte(logic [7:0] b);
        do send_item(1'b0, b); while (!last_taken);
    endtask

    task automatic drain_tick();
        send_item(1'b1, 8'($urandom));
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        wait_idle();
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_WIDTH) cfg_w = val[11:0];
        else if (idx == CFG_HEIGHT) cfg_h = val;
        else if (idx == CFG_WIDE) cfg_wide = val[0];
    endtask

    task automatic set_image(int unsigned w, int unsigned h, bit wide);
        write_cfg(CFG_WIDTH, 16'(w));
        write_cfg(CFG_HEIGHT, 16'(h));
        write_cfg(CFG_WIDE, 16'(wide));
    endtask

    task automatic test_reset_defaults();
        push_byte(8'h34);
        push_byte(8'h12);
        drain_tick();
        push_byte(OP_UL);
    endtask

    task automatic test_narrow_ops();
        set_image(4, 3, 0);
        push_byte(8'h00);
        push_byte(OP_LIT);
        push_byte(8'hFF);
        push_byte(OP_UP1);
        push_byte(8'h00);
        push_byte(OP_UP2);
        push_byte(8'h00);
        push_byte(OP_FILL);
        push_byte(8'h00);
        push_byte(8'h55);
        push_byte(OP_FILL2);
        push_byte(8'h00);
        push_byte(8'hA5);
        push_byte(8'h5A);
        push_byte(OP_UR);
        drain_tick();
    endtask

    task automatic test_wide_ops();
        set_image(1, 5, 1);
        push_byte(OP_UR);
        push_byte(OP_UL);
        set_image(3, 4, 1);
        push_byte(8'h34);
        push_byte(8'h12);
        push_byte(OP_UL);
        push_byte(OP_UR);
        push_byte(OP_PACK);
        push_byte(8'h01);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(OP_UP1);
        push_byte(8'h00);
        // two-colour run long enough to cross the frame end
        push_byte(OP_FILL2);
        push_byte(8'h03);
        push_byte(8'h11);
        push_byte(8'h22);
        push_byte(8'h33);
        push_byte(8'h44);
        push_byte(OP_LIT);
        push_byte(8'hEE);
        push_byte(8'hFF);
    endtask

    task automatic random_burst(int n);
        int start;
        int r;
        start = n_items;
        while (n_items - start < n) begin
            r = $urandom_range(99);
            if (r < 18) drain_tick();
            else if (r < 50) begin
                push_byte(OP_LIT + 8'($urandom_range(7)));
                if ($urandom_range(9) == 0) push_byte(8'($urandom));
                else push_byte(8'($urandom_range(5)));
            end else push_byte(8'($urandom));
        end
    endtask

    task automatic test_random();
        no_idle = 1;
        set_image(5, 3, 1);
        random_burst(80);
        no_idle = 0;
        set_image(4095, 2, 0);
        random_burst(60);
        set_image(0, 0, 1);
        random_burst(40);
        set_image(2048, 2, 1);
        random_burst(60);
        wait_idle();
        set_image(3, 65535, 0);
        random_burst(40);
        for (int k = 0; k < 5; k++) begin
            set_image($urandom_range(1, 9), $urandom_range(1, 5), $urandom_range(1));
            random_burst(55);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_WIDTH;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_w = 1;
        cfg_h = 1;
        cfg_wide = 1;
        pos = 0;
        phase = PH_IDLE;
        cur_op = '0;
        run_cnt = 0;
        col_a = '0;
        col_b = '0;
        hi_half = '0;
        lo_byte = '0;
        alt = 0;
        foreach (hist_mem[i]) hist_mem[i] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_narrow_ops();
        test_wide_ops();
        test_random();
        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Covered %0d items, %0d pixels, %0d frames, %0d refused bytes", n_items,
                 n_pixels, n_frames, n_refused);
        $display("across 8/16-bit modes and width/height extremes; %0d errors", errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
